/* rtl/ieps_pkg.sv */
// ----------------------------------------------------------------------------
// ieps_pkg: shared types and constants of the EEPROM pin sequencer.
// Holds the payload structs and the item codes used by all modules.
// ----------------------------------------------------------------------------
package ieps_pkg;

  localparam int PageBytesDefault = 16;
  localparam int BufDepth = 16;
  localparam logic [19:0] WaitResetTicks = 20'd5000;
  localparam logic [6:0] DevAddrReset = 7'd80;
  localparam int CfgDataWidth = 20;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef enum logic {
    CFG_DEV_ADDR = 1'b0,
    CFG_WAIT     = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] mem_addr;
    logic [8:0] length;
    logic [3:0] buffer_index;
    logic [7:0] data_byte;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_data;
    logic       nack_seen;
  } out_item_t;

endpackage

/* rtl/i2c_eeprom_pin_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// i2c_eeprom_pin_sequencer_unit: I2C master for a 24-series EEPROM.
// Queue-style input and result ports; one result per input beat.
// ----------------------------------------------------------------------------
// Every input beat yields exactly one result beat. The unit takes one beat
// per clock when results are drained; an accepted beat is registered in the
// input queue, the sequencer steps it once the result queue has room or is
// being popped and writes its result to the result queue, from which it is
// presented on the result ports until it is popped.
module i2c_eeprom_pin_sequencer_unit #(
  parameter int PAGE_BYTES = ieps_pkg::PageBytesDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  ieps_pkg::in_item_t  din,
  output logic                empty,
  input  logic                pop,
  output ieps_pkg::out_item_t dout,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [ieps_pkg::CfgDataWidth-1:0] cfg_data
);
  import ieps_pkg::*;

  logic     q_valid, q_take;
  in_item_t q_item;

  ieps_front u_front (
    .clk, .rst, .push, .full, .din, .q_valid, .q_item, .q_take
  );

  ieps_back #(.PAGE_BYTES(PAGE_BYTES)) u_back (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .q_valid, .q_item, .q_take,
    .empty, .pop, .dout
  );

  // A read byte is reported only with SCL driven low.
  a_read_scl: assert property (@(posedge clk) disable iff (rst)
    (!empty && dout.read_valid) |-> !dout.scl) else $error("read with scl high");

  // Result data is zero when no byte completes.
  a_rdata: assert property (@(posedge clk) disable iff (rst)
    (!empty && !dout.read_valid) |-> dout.read_data == 8'd0) else $error("stray data");

  // A pending result is not lost without a pop.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty) else $error("result dropped");

endmodule

/* rtl/ieps_front.sv */
// ----------------------------------------------------------------------------
// ieps_front: input stage.
// Registers each accepted beat and passes it to the sequencer when it can.
// ----------------------------------------------------------------------------
module ieps_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  ieps_pkg::in_item_t din,
  output logic               q_valid,
  output ieps_pkg::in_item_t q_item,
  input  logic               q_take
);
  import ieps_pkg::*;

  // Two-entry queue lets the front keep accepting while the back stalls.
  in_item_t   mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        mem[wr_ptr] <= din;
        wr_ptr <= ~wr_ptr;
      end
      if (q_take && q_valid) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push && !full) - 2'(q_take && q_valid);
    end
  end

endmodule

/* rtl/ieps_back.sv */
// ----------------------------------------------------------------------------
// ieps_back: bus sequencer.
// Executes one item per cycle while the result queue has room or is being popped,
// and stores its result in a two-entry queue.
module ieps_back #(
  parameter int PAGE_BYTES = ieps_pkg::PageBytesDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [19:0]         cfg_data,
  input  logic                q_valid,
  input  ieps_pkg::in_item_t  q_item,
  output logic                q_take,
  output logic                empty,
  input  logic                pop,
  output ieps_pkg::out_item_t dout
);
  import ieps_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_W_START, PH_W_DEV, PH_W_DEV_ACK, PH_W_ADDR, PH_W_ADDR_ACK,
    PH_W_DATA, PH_W_DATA_ACK, PH_W_STOP, PH_W_WAIT, PH_R_START, PH_R_DEV,
    PH_R_DEV_ACK, PH_R_ADDR, PH_R_ADDR_ACK, PH_R_RSTART, PH_R_DEVR,
    PH_R_DEVR_ACK, PH_R_READ, PH_R_NACK, PH_R_STOP
  } phase_t;

  localparam logic [8:0] PageLen = 9'(PAGE_BYTES);

  logic [6:0]  dev_addr;
  logic [19:0] wait_ticks;
  phase_t      phase, phase_next;
  logic [1:0]  sub_step, sub_next;
  logic [2:0]  bit_count, bit_next;
  logic [7:0]  shift_byte, shift_next, cur_addr, cur_addr_next;
  logic [8:0]  bytes_left, left_next;
  logic [3:0]  buf_ptr, ptr_next;
  logic [19:0] wait_count, wait_next;
  logic        scl, sda, scl_next, sda_next;
  logic        rvalid, nack;
  logic [7:0]  rdata;
  logic [7:0]  page_buffer [BufDepth];
  logic [8:0]  wlen;

  // Result queue.
  out_item_t  oq [2];
  logic       owp, orp;
  logic [1:0] ocount;
  logic       fire;

  assign empty  = (ocount == 2'd0);
  assign dout   = oq[orp];
  assign q_take = (ocount != 2'd2) || pop;
  assign fire   = q_valid && q_take;

  assign wlen     = (q_item.length > PageLen) ? PageLen : q_item.length;

  always_comb begin
    phase_next    = phase;
    sub_next      = sub_step;
    bit_next      = bit_count;
    shift_next    = shift_byte;
    cur_addr_next = cur_addr;
    left_next     = bytes_left;
    ptr_next      = buf_ptr;
    wait_next     = wait_count;
    scl_next      = scl;
    sda_next      = sda;
    rvalid        = 1'b0;
    rdata         = 8'd0;
    nack          = 1'b0;
    unique case (kind_t'(q_item.kind))
      KIND_LOAD: ;
      KIND_WRITE: begin
        if (phase == PH_IDLE) begin
          cur_addr_next = q_item.mem_addr;
          left_next     = wlen;
          ptr_next      = 4'd0;
          phase_next    = PH_W_START;
          sub_next      = 2'd0;
          bit_next      = 3'd0;
        end
      end
      KIND_READ: begin
        if (phase == PH_IDLE && q_item.length != 9'd0) begin
          cur_addr_next = q_item.mem_addr;
          left_next     = q_item.length;
          phase_next    = PH_R_START;
          sub_next      = 2'd0;
          bit_next      = 3'd0;
        end
      end
      KIND_TICK: begin
        // Stepping: at most one pin write per tick; sub_next advanced by default.
        sub_next = sub_step + 2'd1;
        unique case (phase)
          PH_W_START, PH_R_START, PH_R_RSTART: begin
            unique case (sub_step)
              2'd0: sda_next = 1'b1;
              2'd1: scl_next = 1'b1;
              2'd2: sda_next = 1'b0;
              default: scl_next = 1'b0;
            endcase
          end
          PH_W_DEV, PH_W_ADDR, PH_W_DATA, PH_R_DEV, PH_R_ADDR, PH_R_DEVR: begin
            if (sub_step == 2'd0) sda_next = shift_byte[3'd7 - bit_count];
            else if (sub_step == 2'd1) scl_next = 1'b1;
            else begin
              scl_next = 1'b0;
              sub_next = 2'd0;
              bit_next = bit_count + 3'd1;
            end
          end
          PH_W_DEV_ACK, PH_W_ADDR_ACK, PH_W_DATA_ACK, PH_R_DEV_ACK,
          PH_R_ADDR_ACK, PH_R_DEVR_ACK, PH_R_NACK: begin
            if (sub_step == 2'd0) sda_next = 1'b1;
            else if (sub_step == 2'd1) scl_next = 1'b1;
            else begin
              scl_next = 1'b0;
              nack = (phase != PH_R_NACK) && q_item.sda_in;
            end
          end
          PH_R_READ: begin
            if (sub_step == 2'd0) begin
              sda_next   = 1'b1;
              shift_next = 8'd0;
            end else if (sub_step == 2'd1) scl_next = 1'b1;
            else begin
              scl_next   = 1'b0;
              shift_next = {shift_byte[6:0], q_item.sda_in};
              sub_next   = 2'd1;
              bit_next   = bit_count + 3'd1;
              if (bit_count == 3'd7) begin
                rvalid    = 1'b1;
                rdata     = shift_next;
                left_next = bytes_left - 9'd1;
              end
            end
          end
          PH_W_STOP, PH_R_STOP: begin
            if (sub_step == 2'd0) sda_next = 1'b0;
            else if (sub_step == 2'd1) scl_next = 1'b1;
            else sda_next = 1'b1;
          end
          PH_W_WAIT: begin
            if (wait_count > 20'd0) wait_next = wait_count - 20'd1;
            if (wait_count <= 20'd1) phase_next = PH_IDLE;
          end
          default: sub_next = sub_step;
        endcase

        // Phase completion: start is four steps, others end on step two.
        if ((phase == PH_W_START || phase == PH_R_START || phase == PH_R_RSTART)
            ? (sub_step == 2'd3)
            : ((sub_step == 2'd2) && phase != PH_IDLE && phase != PH_W_WAIT &&
               !((phase == PH_W_DEV || phase == PH_W_ADDR || phase == PH_W_DATA ||
                  phase == PH_R_DEV || phase == PH_R_ADDR || phase == PH_R_DEVR ||
                  phase == PH_R_READ) && bit_count != 3'd7))) begin
          sub_next = 2'd0;
          bit_next = 3'd0;
          unique case (phase)
            PH_W_START: begin
              phase_next = PH_W_DEV;
              shift_next = {dev_addr, 1'b0};
            end
            PH_W_DEV:     phase_next = PH_W_DEV_ACK;
            PH_W_DEV_ACK: begin
              phase_next = PH_W_ADDR;
              shift_next = cur_addr;
            end
            PH_W_ADDR:    phase_next = PH_W_ADDR_ACK;
            PH_W_DATA:    phase_next = PH_W_DATA_ACK;
            PH_W_ADDR_ACK, PH_W_DATA_ACK: begin
              if (bytes_left != 9'd0) begin
                phase_next = PH_W_DATA;
                shift_next = page_buffer[buf_ptr];
                ptr_next   = buf_ptr + 4'd1;
                left_next  = bytes_left - 9'd1;
              end else phase_next = PH_W_STOP;
            end
            PH_W_STOP: begin
              if (wait_ticks != 20'd0) begin
                phase_next = PH_W_WAIT;
                wait_next  = wait_ticks;
              end else phase_next = PH_IDLE;
            end
            PH_R_START: begin
              phase_next = PH_R_DEV;
              shift_next = {dev_addr, 1'b0};
            end
            PH_R_DEV:     phase_next = PH_R_DEV_ACK;
            PH_R_DEV_ACK: begin
              phase_next = PH_R_ADDR;
              shift_next = cur_addr;
            end
            PH_R_ADDR:     phase_next = PH_R_ADDR_ACK;
            PH_R_ADDR_ACK: phase_next = PH_R_RSTART;
            PH_R_RSTART: begin
              phase_next = PH_R_DEVR;
              shift_next = {dev_addr, 1'b1};
            end
            PH_R_DEVR:     phase_next = PH_R_DEVR_ACK;
            PH_R_DEVR_ACK: phase_next = PH_R_READ;
            PH_R_READ:     phase_next = PH_R_NACK;
            PH_R_NACK:     phase_next = PH_R_STOP;
            PH_R_STOP: begin
              if (left_next != 9'd0) begin
                cur_addr_next = cur_addr + 8'd1;
                phase_next    = PH_R_START;
              end else phase_next = PH_IDLE;
            end
            default: phase_next = PH_IDLE;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Sequencer state, configuration and result queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr   <= DevAddrReset;
      wait_ticks <= WaitResetTicks;
      phase      <= PH_IDLE;
      sub_step   <= 2'd0;
      bit_count  <= 3'd0;
      shift_byte <= 8'd0;
      cur_addr   <= 8'd0;
      bytes_left <= 9'd0;
      buf_ptr    <= 4'd0;
      wait_count <= 20'd0;
      scl        <= 1'b1;
      sda        <= 1'b1;
      owp        <= 1'b0;
      orp        <= 1'b0;
      ocount     <= 2'd0;
    end else begin
      if (cfg_we) begin
        if (cfg_reg_t'(cfg_index) == CFG_DEV_ADDR) dev_addr <= cfg_data[6:0];
        else wait_ticks <= cfg_data;
      end
      if (fire) begin
        phase      <= phase_next;
        sub_step   <= sub_next;
        bit_count  <= bit_next;
        shift_byte <= shift_next;
        cur_addr   <= cur_addr_next;
        bytes_left <= left_next;
        buf_ptr    <= ptr_next;
        wait_count <= wait_next;
        scl        <= scl_next;
        sda        <= sda_next;
        oq[owp]    <= '{scl: scl_next, sda_out: sda_next,
                        busy_res: (phase_next != PH_IDLE), read_valid: rvalid,
                        read_data: rdata, nack_seen: nack};
        owp        <= ~owp;
      end
      if (pop && !empty) orp <= ~orp;
      ocount <= ocount + 2'(fire) - 2'(pop && !empty);
    end
  end

  // Page buffer writes from load beats.
  always_ff @(posedge clk) begin
    if (fire && kind_t'(q_item.kind) == KIND_LOAD)
      page_buffer[q_item.buffer_index] <= q_item.data_byte;
  end

endmodule
